// ===== rtl/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg: shared types and constants of the priority scheduler
// Field widths, the scan record that moves along the cell row, FSM states.
// ----------------------------------------------------------------------------
package nps_pkg;

	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int ID_W    = 6;
	localparam int TIME_W  = 22;
	localparam int SUM_W   = 27;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 128;

	// Scan record handed from cell to cell, one cell per cycle.
	typedef struct packed {
		logic               vld;        // record present at this boundary
		logic               has_pick;   // an arrived, unfinished job was found
		logic [ID_W-1:0]    pick_id;    // zero-based slot of the best job
		logic [PRIO_W-1:0]  pick_prio;
		logic [ARR_W-1:0]   pick_arr;
		logic [BURST_W-1:0] pick_burst;
		logic               min_vld;    // some unfinished job seen
		logic [ARR_W-1:0]   min_arr;    // earliest arrival of unfinished jobs
	} wave_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_SCAN,
		S_ADV,
		S_TURN,
		S_WAIT,
		S_EMIT
	} state_t;

endpackage

// ===== rtl/nps_cell.sv =====
// ----------------------------------------------------------------------------
// nps_cell: one job slot of the scheduler row
// Holds one job record and folds it into the scan record passing through.
// ----------------------------------------------------------------------------
module nps_cell #(
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [nps_pkg::ARR_W-1:0]   wr_arr,
	input  logic [nps_pkg::BURST_W-1:0] wr_burst,
	input  logic [nps_pkg::PRIO_W-1:0]  wr_prio,
	input  logic                      clr,
	input  logic                      done_set,
	input  logic [nps_pkg::ID_W-1:0]    done_id,
	input  logic [nps_pkg::TIME_W-1:0]  now,
	input  nps_pkg::wave_t            wave_in,
	output nps_pkg::wave_t            wave_out
);
	import nps_pkg::*;

	localparam logic [ID_W-1:0] MY_ID = ID_W'(IDX);

	logic [ARR_W-1:0]   arr_q;
	logic [BURST_W-1:0] burst_q;
	logic [PRIO_W-1:0]  prio_q;
	logic               loaded_q;
	logic               done_q;
	wave_t              wave_q;
	wave_t              wave_nxt;
	logic               live;
	logic               arrived;
	logic               better;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			arr_q   <= wr_arr;
			burst_q <= wr_burst;
			prio_q  <= wr_prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			done_q   <= 1'b0;
		end else if (clr) begin
			loaded_q <= 1'b0;
			done_q   <= 1'b0;
		end else if (wr_en) begin
			loaded_q <= 1'b1;
			done_q   <= 1'b0;
		end else if (done_set && done_id == MY_ID) begin
			done_q <= 1'b1;
		end
	end

	assign live    = loaded_q && !done_q;
	assign arrived = {{(TIME_W-ARR_W){1'b0}}, arr_q} <= now;
	// strict improvement only, so the lower slot keeps a full tie
	assign better  = !wave_in.has_pick || (prio_q < wave_in.pick_prio) ||
		((prio_q == wave_in.pick_prio) && (arr_q < wave_in.pick_arr));

	always_comb begin
		wave_nxt = wave_in;
		if (wave_in.vld && live) begin
			if (arrived && better) begin
				wave_nxt.has_pick   = 1'b1;
				wave_nxt.pick_id    = MY_ID;
				wave_nxt.pick_prio  = prio_q;
				wave_nxt.pick_arr   = arr_q;
				wave_nxt.pick_burst = burst_q;
			end
			if (!wave_in.min_vld || arr_q < wave_in.min_arr) begin
				wave_nxt.min_vld = 1'b1;
				wave_nxt.min_arr = arr_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= '0;
		end else begin
			wave_q <= wave_nxt;
		end
	end

	assign wave_out = wave_q;

endmodule

// ===== rtl/nonpreemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler: non-preemptive priority job scheduler
// Loads job records into a row of cells, then emits jobs in completion order.
// ----------------------------------------------------------------------------
// Job records (arrival, burst, prio) stream in on the s_ group, one transfer
// per cycle, and fill a row of MAX_JOBS cells in load order; records past
// MAX_JOBS are dropped. The transfer with s_tlast high (stored like any other)
// starts a scheduling pass, during which s_tready stays low. Time starts at
// the earliest arrival; each step picks, among arrived unfinished jobs, the
// lowest prio, then the earlier arrival, then the lower job number, and runs
// it to completion. If nothing has arrived, time jumps to the next arrival.
// Each pick is found by a scan record that walks the cell row one cell per
// cycle, so each completed job takes a scan of the row plus four arithmetic
// steps, and each idle jump adds a fresh scan. A stalled m_ side holds the
// pass in its emit step until the previous result is taken. One result per
// job leaves on the m_ group, m_tlast marking the last job of the batch;
// totals run over the batch. After the last result is built the block clears
// its store and takes the next batch at once, while that result may still
// wait in the output register.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler #(
	parameter int MAX_JOBS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// arrival[15:0], burst[31:16], prio[39:32]
	input  logic [nps_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tlast,   // last_job
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// job_id[5:0], finish_time[27:6], waiting[49:28], turnaround[71:50],
	// total_waiting[98:72], total_turnaround[125:99], zero pad [127:126]
	output logic [nps_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tlast    // final_res
);
	import nps_pkg::*;

	localparam int CNT_W = $clog2(MAX_JOBS + 1);

	state_t state_q, state_nxt;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   k_inc;
	logic               is_final;
	logic [TIME_W-1:0]  now_q;
	logic [SUM_W-1:0]   sum_wait_q;
	logic [SUM_W-1:0]   sum_turn_q;
	logic [SUM_W-1:0]   sum_wait_new;
	logic               busy_q;

	logic [ID_W-1:0]    pick_id_q;
	logic [ARR_W-1:0]   pick_arr_q;
	logic [BURST_W-1:0] pick_burst_q;
	logic [TIME_W-1:0]  turn_q;
	logic [TIME_W-1:0]  wait_q;

	logic               out_vld_q;
	logic               out_last_q;
	logic [ID_W-1:0]    out_id_q;
	logic [TIME_W-1:0]  out_fin_q;
	logic [TIME_W-1:0]  out_wait_q;
	logic [TIME_W-1:0]  out_turn_q;
	logic [SUM_W-1:0]   out_twait_q;
	logic [SUM_W-1:0]   out_tturn_q;

	logic               in_xfer;
	logic               store_ok;
	logic               out_free;
	logic               launch;
	logic               emit;
	logic               clr_pass;

	logic [ARR_W-1:0]   in_arr;
	logic [BURST_W-1:0] in_burst;
	logic [PRIO_W-1:0]  in_prio;

	wave_t              wave_launch;
	wave_t              wave_end;
	wave_t              wave_link [MAX_JOBS+1];

	assign in_arr   = s_tdata[ARR_W-1:0];
	assign in_burst = s_tdata[ARR_W+BURST_W-1:ARR_W];
	assign in_prio  = s_tdata[ARR_W+BURST_W+PRIO_W-1:ARR_W+BURST_W];

	assign in_xfer  = s_tvalid && s_tready;
	assign store_ok = count_q < CNT_W'(MAX_JOBS);
	assign out_free = !out_vld_q || m_tready;
	assign k_inc    = k_q + CNT_W'(1);
	assign is_final = (k_inc == count_q);
	assign sum_wait_new = sum_wait_q + {{(SUM_W-TIME_W){1'b0}}, wait_q};
	assign clr_pass = emit && is_final;

	// ---------------------------------------------------------------- cell row
	always_comb begin
		wave_launch     = '0;
		wave_launch.vld = launch;
	end

	assign wave_link[0] = wave_launch;

	for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
		nps_cell #(
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (in_xfer && store_ok && (count_q == CNT_W'(i))),
			.wr_arr   (in_arr),
			.wr_burst (in_burst),
			.wr_prio  (in_prio),
			.clr      (clr_pass),
			.done_set (emit),
			.done_id  (pick_id_q),
			.now      (now_q),
			.wave_in  (wave_link[i]),
			.wave_out (wave_link[i+1])
		);
	end

	assign wave_end = wave_link[MAX_JOBS];

	// ------------------------------------------------------------- next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_LOAD: begin
				if (in_xfer && s_tlast) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (wave_end.vld && wave_end.has_pick) state_nxt = S_ADV;
			end
			S_ADV:  state_nxt = S_TURN;
			S_TURN: state_nxt = S_WAIT;
			S_WAIT: state_nxt = S_EMIT;
			S_EMIT: begin
				if (out_free) state_nxt = is_final ? S_LOAD : S_SCAN;
			end
			default: state_nxt = S_LOAD;
		endcase
	end

	// ---------------------------------------------------------------- outputs
	always_comb begin
		s_tready = 1'b0;
		launch   = 1'b0;
		emit     = 1'b0;
		case (state_q)
			S_LOAD: s_tready = 1'b1;
			S_SCAN: launch   = !busy_q;
			S_EMIT: emit     = out_free;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// -------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			count_q    <= '0;
			k_q        <= '0;
			now_q      <= '0;
			sum_wait_q <= '0;
			sum_turn_q <= '0;
			busy_q     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;

			// fill count; hold once the row is full
			if (in_xfer && store_ok) count_q <= count_q + CNT_W'(1);

			// scan bookkeeping: one record in flight at a time
			if (launch) begin
				busy_q <= 1'b1;
			end else if (wave_end.vld) begin
				busy_q <= 1'b0;
				// nothing arrived: jump to the earliest unfinished arrival
				if (!wave_end.has_pick) begin
					now_q <= {{(TIME_W-ARR_W){1'b0}}, wave_end.min_arr};
				end
			end

			if (state_q == S_ADV) begin
				now_q <= now_q + {{(TIME_W-BURST_W){1'b0}}, pick_burst_q};
			end
			if (state_q == S_WAIT) begin
				sum_turn_q <= sum_turn_q + {{(SUM_W-TIME_W){1'b0}}, turn_q};
			end

			if (m_tready) out_vld_q <= 1'b0;
			if (emit) begin
				out_vld_q  <= 1'b1;
				k_q        <= k_inc;
				sum_wait_q <= sum_wait_new;
			end

			// batch done: return to the empty state
			if (clr_pass) begin
				count_q    <= '0;
				k_q        <= '0;
				now_q      <= '0;
				sum_wait_q <= '0;
				sum_turn_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (wave_end.vld && wave_end.has_pick) begin
			pick_id_q    <= wave_end.pick_id;
			pick_arr_q   <= wave_end.pick_arr;
			pick_burst_q <= wave_end.pick_burst;
		end
		if (state_q == S_TURN) begin
			turn_q <= now_q - {{(TIME_W-ARR_W){1'b0}}, pick_arr_q};
		end
		if (state_q == S_WAIT) begin
			wait_q <= turn_q - {{(TIME_W-BURST_W){1'b0}}, pick_burst_q};
		end
		if (emit) begin
			out_id_q    <= pick_id_q + ID_W'(1);
			out_fin_q   <= now_q;
			out_wait_q  <= wait_q;
			out_turn_q  <= turn_q;
			out_twait_q <= sum_wait_new;
			out_tturn_q <= sum_turn_q;
			out_last_q  <= is_final;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_tturn_q, out_twait_q, out_turn_q, out_wait_q,
		out_fin_q, out_id_q};

	// ------------------------------------------------------------- assertions
	a_busy_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (state_q == S_SCAN))
		else $error("scan record in flight outside the scan state");

	a_end_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wave_end.vld |-> busy_q)
		else $error("scan record emerged with none launched");

	a_pick_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		(wave_end.vld && wave_end.has_pick) |->
		({{(TIME_W-ARR_W){1'b0}}, wave_end.pick_arr} <= now_q))
		else $error("picked job has not arrived yet");

	a_pass_has_jobs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> (count_q != '0 && k_q < count_q))
		else $error("scheduling pass without pending jobs");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_vld_q || m_tready))
		else $error("result overwrites an untaken result");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench of nonpreemptive_priority_scheduler
// Streams batches of job records into the scheduler and checks every
// completion record against hand-typed results or a behavioral scheduler kept in the bench.
// ----------------------------------------------------------------------------
// The directed plan covers single-job batches at the field extremes, priority,
// arrival and job-number ties, idle jumps and alternating bit patterns. The
// random part follows: one batch that overflows the store (its last record is
// dropped, the pass still runs), one batch that fills the store exactly, then
// short batches with either crowded or widely spread arrivals. Both sides
// idle at random, with quiet stretches, and the sender holds off until all
// completions have drained after the directed plan and now and then between
// batches.
// ----------------------------------------------------------------------------
module tb;

	import nps_pkg::*;

	localparam int MAX_JOBS    = 32;
	localparam int RAND_ITEMS  = 80;
	localparam int STALL_LIMIT = 20000;	// cycles with no transfer on either side
	localparam int TAIL_CYCLES = 200;	// a few job times, to catch stray results
	localparam int N_PLAN      = 18;

	typedef struct packed {
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		logic               last;
	} job_t;

	typedef struct packed {
		logic [ID_W-1:0]   job_id;
		logic [TIME_W-1:0] finish;
		logic [TIME_W-1:0] waited;
		logic [TIME_W-1:0] turnaround;
		logic [SUM_W-1:0]  sum_waited;
		logic [SUM_W-1:0]  sum_turnaround;
		logic              final_res;
	} done_rec_t;

	typedef struct packed {
		job_t      job;
		logic      typed;	// completion below is known by hand
		done_rec_t want;
	} plan_row_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata  = '0;
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;

	// bench copy of the job store
	int unsigned st_arr   [MAX_JOBS];
	int unsigned st_burst [MAX_JOBS];
	int unsigned st_prio  [MAX_JOBS];
	int unsigned stored = 0;

	done_rec_t due_completions [$];
	int        mismatches   = 0;
	int        quiet_cycles = 0;
	bit        tx_steady    = 1'b0;
	bit        rx_steady    = 1'b0;
	int        rx_hold      = 0;

	plan_row_t plan [N_PLAN];

	nonpreemptive_priority_scheduler #(
		.MAX_JOBS(MAX_JOBS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// served first: lower prio, then earlier arrival, then lower job number
	function automatic bit ahead_of(int a, int b);
		if (st_prio[a] != st_prio[b]) return st_prio[a] < st_prio[b];
		if (st_arr[a] != st_arr[b]) return st_arr[a] < st_arr[b];
		return a < b;
	endfunction

	// Store one record; on the last record run the whole batch and queue
	// one completion per job in the order the jobs finish.
	task automatic load_job(input job_t j);
		int unsigned n, now, nxt, turn, waited, sw, stn;
		int          pick;
		bit          have_nxt;
		bit          done [MAX_JOBS];
		done_rec_t   r;
		if (stored < MAX_JOBS) begin
			st_arr[stored]   = 32'(j.arrival);
			st_burst[stored] = 32'(j.burst);
			st_prio[stored]  = 32'(j.prio);
			stored++;
		end
		if (!j.last) return;
		n   = stored;
		now = st_arr[0];
		for (int i = 1; i < n; i++)
			if (st_arr[i] < now) now = st_arr[i];
		sw  = 0;
		stn = 0;
		for (int i = 0; i < MAX_JOBS; i++) done[i] = 1'b0;
		for (int k = 0; k < n; k++) begin
			pick     = -1;
			have_nxt = 1'b0;
			nxt      = 0;
			for (int i = 0; i < n; i++) begin
				if (!done[i]) begin
					if (st_arr[i] <= now) begin
						if (pick < 0 || ahead_of(i, pick)) pick = i;
					end else if (!have_nxt || st_arr[i] < nxt) begin
						nxt      = st_arr[i];
						have_nxt = 1'b1;
					end
				end
			end
			if (pick < 0) begin
				// nothing has arrived: jump ahead and choose again
				now = nxt;
				for (int i = 0; i < n; i++)
					if (!done[i] && st_arr[i] <= now && (pick < 0 || ahead_of(i, pick)))
						pick = i;
			end
			done[pick] = 1'b1;
			now    += st_burst[pick];
			turn   = now - st_arr[pick];
			waited = turn - st_burst[pick];
			sw     += waited;
			stn    += turn;
			r.job_id         = ID_W'(pick + 1);
			r.finish         = TIME_W'(now);
			r.waited         = TIME_W'(waited);
			r.turnaround     = TIME_W'(turn);
			r.sum_waited     = SUM_W'(sw);
			r.sum_turnaround = SUM_W'(stn);
			r.final_res      = (k == n - 1);
			due_completions.push_back(r);
		end
		stored = 0;
	endtask

	// Offer one record, hold it until accepted, then account for it.
	task automatic put_job(input job_t j, input logic typed, input done_rec_t want);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {j.prio, j.burst, j.arrival};
		s_tlast  <= j.last;
		do @(posedge clk); while (!s_tready);
		// typed rows are single-job batches, so the bench store is empty here
		if (typed) due_completions.push_back(want);
		else load_job(j);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_completions.size() != 0);
	endtask

	task automatic check_field(input string what, input logic [31:0] want, got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	task automatic check_completion(input logic [M_DATA_W-1:0] d, input logic last);
		done_rec_t got, want;
		got.job_id         = d[5:0];
		got.finish         = d[27:6];
		got.waited         = d[49:28];
		got.turnaround     = d[71:50];
		got.sum_waited     = d[98:72];
		got.sum_turnaround = d[125:99];
		got.final_res      = last;
		if (due_completions.size() == 0) begin
			$display("%0t: unexpected completion, job %0d finish %0d",
				$time, got.job_id, got.finish);
			mismatches++;
			return;
		end
		want = due_completions.pop_front();
		check_field("job_id",           32'(want.job_id),         32'(got.job_id));
		check_field("finish_time",      32'(want.finish),         32'(got.finish));
		check_field("waiting",          32'(want.waited),         32'(got.waited));
		check_field("turnaround",       32'(want.turnaround),     32'(got.turnaround));
		check_field("total_waiting",    32'(want.sum_waited),     32'(got.sum_waited));
		check_field("total_turnaround", 32'(want.sum_turnaround), 32'(got.sum_turnaround));
		check_field("final_res",        32'(want.final_res),      32'(got.final_res));
	endtask

	// Completion side: check transfers, stall at random, count quiet cycles.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) check_completion(m_tdata, m_tlast);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles = 0;
		else quiet_cycles++;
		if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= 1'b1;
			if (!rx_steady) rx_hold = pick_gap();
		end
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("[nonpreemptive_priority_scheduler] ERROR");
		$finish;
	end

	initial begin
		job_t j;
		int   sent, size, batch;
		bit   crowded;

		// arrival, burst, prio, last | typed | id, finish, wait, turn, sums, final
		plan = '{
			// lone job, all zero
			'{'{0, 0, 0, 1}, 1, '{1, 0, 0, 0, 0, 0, 1}},
			// lone job, all fields at their maximum
			'{'{65535, 65535, 255, 1}, 1, '{1, 131070, 0, 65535, 0, 65535, 1}},
			// lone job with zero burst
			'{'{65535, 0, 255, 1}, 1, '{1, 65535, 0, 0, 0, 0, 1}},
			// ties on prio and arrival, earlier arrival, idle jump after job 5
			'{'{100, 20, 5, 0}, 0, '0},
			'{'{100, 20, 5, 0}, 0, '0},
			'{'{90, 10, 5, 0}, 0, '0},
			'{'{95, 30, 1, 0}, 0, '0},
			'{'{0, 7, 255, 1}, 0, '0},
			// common arrival, prio extremes, job number breaks the last tie
			'{'{300, 5, 255, 0}, 0, '0},
			'{'{300, 5, 0, 0}, 0, '0},
			'{'{300, 5, 128, 0}, 0, '0},
			'{'{300, 65535, 0, 1}, 0, '0},
			// long bursts pile up waiting time
			'{'{65535, 1, 0, 0}, 0, '0},
			'{'{0, 65535, 200, 0}, 0, '0},
			'{'{1, 65535, 100, 1}, 0, '0},
			// alternating bit patterns
			'{'{43690, 21845, 170, 0}, 0, '0},
			'{'{21845, 43690, 85, 1}, 0, '0},
			'{'{1, 1, 1, 1}, 1, '{1, 2, 0, 1, 0, 1, 1}}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) put_job(plan[r].job, plan[r].typed, plan[r].want);
		hold_until_drained();

		sent  = 0;
		batch = 0;
		while (sent < RAND_ITEMS) begin
			// first an overflowing batch, then one that fills the store exactly
			if (batch == 0) size = MAX_JOBS + 1;
			else if (batch == 1) size = MAX_JOBS;
			else size = $urandom_range(1, 8);
			crowded   = 1'($urandom_range(0, 1));
			tx_steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < size; k++) begin
				if (crowded) begin
					j.arrival = ARR_W'($urandom_range(0, 63));
					j.burst   = BURST_W'($urandom_range(0, 15));
					j.prio    = PRIO_W'($urandom_range(0, 3));
				end else begin
					j.arrival = ARR_W'($urandom);
					j.burst   = BURST_W'($urandom);
					j.prio    = PRIO_W'($urandom);
				end
				j.last = (k == size - 1);
				put_job(j, 1'b0, '0);
			end
			sent += size;
			batch++;
			if ($urandom_range(0, 3) == 0) hold_until_drained();
		end
		tx_steady = 1'b0;

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_completions.size() == 0)
			$display("[nonpreemptive_priority_scheduler] OK");
		else
			$display("[nonpreemptive_priority_scheduler] ERROR");
		$finish;
	end

endmodule
